@@ hw/rtl/qog_pkg.sv @@
// ----------------------------------------------------------------------------
// qog_pkg: shared types and constants for the quadratic objective/gradient block
// Item structs, operation codes, controller states and the cell control bundle.
// ----------------------------------------------------------------------------
package qog_pkg;

    localparam int DEF_MAX_VARS = 16;   // default number of stored variables
    localparam int ELEM_LIMIT   = 16;   // element index field tops out here
    localparam int VAL_W        = 16;   // Q8.8 element width
    localparam int PROD_W       = 32;   // Q16.16 product width
    localparam int TRIPLE_W     = 48;   // x * Q * x product width
    localparam int ACC_W        = 40;   // per-element sums
    localparam int RES_W        = 64;   // Q24.24 result width
    localparam int CFG_W        = 5;    // active_vars register width
    localparam int ELEM_W       = 4;    // row / col / element index width

    // Operation codes of an input item
    typedef enum logic [1:0] {
        OP_WR_MATRIX = 2'd0,
        OP_WR_LINEAR = 2'd1,
        OP_WR_POINT  = 2'd2,
        OP_EVAL      = 2'd3
    } op_t;

    // Result kinds
    localparam logic KIND_OBJ  = 1'b0;
    localparam logic KIND_GRAD = 1'b1;

    typedef struct packed {
        logic [1:0]              operation;
        logic [ELEM_W-1:0]       row;
        logic [ELEM_W-1:0]       col;
        logic signed [VAL_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic                    kind;
        logic [ELEM_W-1:0]       element;
        logic signed [RES_W-1:0] result_value;
        logic                    last;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_OBJ,
        ST_GRAD
    } state_t;

    // Per-cell control
    typedef struct packed {
        logic x_we;      // load point element
        logic l_we;      // load linear term
        logic x_shift;   // rotate point ring
        logic acc_clr;   // clear gradient sum
        logic acc_shift; // rotate gradient sum ring
        logic add_en;    // fold a finished row product into this cell
    } cell_ctl_t;

endpackage

@@ hw/rtl/quadratic_objective_gradient_top.sv @@
// ----------------------------------------------------------------------------
// quadratic_objective_gradient_top: quadratic form and gradient evaluator
// Loads Q, l and x element by element and evaluates x'Qx/2 + l'x and its
// gradient l + (Q+Q')x/2 in Q24.24 on request.
// ----------------------------------------------------------------------------
// A load item writes a matrix entry, a linear term or a point element.
// An evaluate item walks the active n by n square of Q, n being the active
// variable count: the walk reads one matrix entry per cycle from the
// registered matrix read port, while the point values and the gradient
// sums rotate through a ring of n cells. The objective and then n gradient
// elements follow, one per cycle when the result side is ready. New items are
// taken once the last result has gone to the output register.
module quadratic_objective_gradient_top import qog_pkg::*; #(
    parameter int MAX_VARS = DEF_MAX_VARS
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_item_t         s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output out_item_t        m_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int IW        = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
    localparam int MEM_DEPTH = 2 ** (2 * IW);
    localparam int NLIM      = (MAX_VARS < ELEM_LIMIT) ? MAX_VARS : ELEM_LIMIT;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] active_vars_reg;
    logic [CFG_W-1:0] n_eff;
    logic [ELEM_W-1:0] n_m1;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_vars_reg <= CFG_W'(16);
        end else if (cfg_valid && cfg_ready) begin
            active_vars_reg <= cfg_data;
        end
    end

    always_comb begin
        if (active_vars_reg == '0) begin
            n_eff = CFG_W'(1);
        end else if (active_vars_reg > CFG_W'(NLIM)) begin
            n_eff = CFG_W'(NLIM);
        end else begin
            n_eff = active_vars_reg;
        end
    end

    assign n_m1 = ELEM_W'(n_eff - CFG_W'(1));

    // ------------------------------------------------------------------
    // Controller
    // ------------------------------------------------------------------
    state_t state_reg, state_next;
    logic in_fire, eval_start, walk_en, walk_done, out_free, obj_load, grad_load;
    logic pipe_busy;
    logic [ELEM_W-1:0] i_reg, i_next, j_reg, j_next, e_reg, e_next;
    logic v1_reg, v2_reg, v3_reg;
    logic m_valid_reg;

    assign in_fire    = s_valid && s_ready;
    assign eval_start = in_fire && (op_t'(s_data.operation) == OP_EVAL);
    assign walk_done  = (i_reg == n_m1) && (j_reg == n_m1);
    assign out_free   = !m_valid_reg || m_ready;
    assign pipe_busy  = v1_reg || v2_reg || v3_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (eval_start) state_next = ST_WALK;
            ST_WALK:  if (walk_done) state_next = ST_DRAIN;
            ST_DRAIN: if (!pipe_busy) state_next = ST_OBJ;
            ST_OBJ:   if (out_free) state_next = ST_GRAD;
            ST_GRAD:  if (out_free && (e_reg == n_m1)) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Controller outputs
    always_comb begin
        s_ready   = 1'b0;
        walk_en   = 1'b0;
        obj_load  = 1'b0;
        grad_load = 1'b0;
        case (state_reg)
            ST_IDLE:  s_ready = 1'b1;
            ST_WALK:  walk_en = 1'b1;
            ST_OBJ:   obj_load = out_free;
            ST_GRAD:  grad_load = out_free;
            default:  s_ready = 1'b0;
        endcase
    end

    // Walk and emit counters
    always_comb begin
        i_next = i_reg;
        j_next = j_reg;
        e_next = e_reg;
        if (eval_start) begin
            i_next = '0;
            j_next = '0;
            e_next = '0;
        end else if (walk_en) begin
            if (j_reg == n_m1) begin
                j_next = '0;
                i_next = walk_done ? i_reg : i_reg + ELEM_W'(1);
            end else begin
                j_next = j_reg + ELEM_W'(1);
            end
        end else if (grad_load) begin
            e_next = e_reg + ELEM_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            e_reg     <= '0;
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            e_reg     <= e_next;
        end
    end

    // ------------------------------------------------------------------
    // Load decode
    // ------------------------------------------------------------------
    logic row_ok, col_ok;
    logic [IW-1:0] row_ix, col_ix, i_ix, j_ix, sel_ix;
    logic mat_we, lin_we, pt_we;

    assign row_ok = int'(s_data.row) < MAX_VARS;
    assign col_ok = int'(s_data.col) < MAX_VARS;
    assign row_ix = IW'(s_data.row);
    assign col_ix = IW'(s_data.col);
    assign i_ix   = IW'(i_reg);
    assign j_ix   = IW'(j_reg);
    assign sel_ix = walk_en ? i_ix : IW'(e_reg);

    assign mat_we = in_fire && (op_t'(s_data.operation) == OP_WR_MATRIX) && row_ok && col_ok;
    assign lin_we = in_fire && (op_t'(s_data.operation) == OP_WR_LINEAR) && row_ok;
    assign pt_we  = in_fire && (op_t'(s_data.operation) == OP_WR_POINT) && row_ok;

    // ------------------------------------------------------------------
    // Matrix memory: one write port, one registered read port
    // ------------------------------------------------------------------
    logic signed [VAL_W-1:0] qmem [MEM_DEPTH];
    logic signed [VAL_W-1:0] q_reg;

    always_ff @(posedge aclk) begin
        if (mat_we) begin
            qmem[{row_ix, col_ix}] <= s_data.value;
        end
    end

    always_ff @(posedge aclk) begin
        if (walk_en) begin
            q_reg <= qmem[{i_ix, j_ix}];
        end
    end

    // ------------------------------------------------------------------
    // Cell ring
    // ------------------------------------------------------------------
    logic signed [VAL_W-1:0] x_c   [MAX_VARS];
    logic signed [VAL_W-1:0] l_c   [MAX_VARS];
    logic signed [ACC_W-1:0] acc_c [MAX_VARS];
    logic signed [ACC_W-1:0] tail_acc, r_final;
    logic signed [PROD_W-1:0] p2_reg;
    logic last2_reg;
    logic [ELEM_W-1:0] i2_reg;

    assign tail_acc = acc_c[0] + ACC_W'(p2_reg);

    for (genvar p = 0; p < MAX_VARS; p++) begin : g_cell
        cell_ctl_t               ctl;
        logic                    active;
        logic signed [VAL_W-1:0] x_from;
        logic signed [ACC_W-1:0] acc_from;

        assign active  = p < int'(n_eff);

        assign ctl.x_we      = pt_we && (int'(row_ix) == p);
        assign ctl.l_we      = lin_we && (int'(row_ix) == p);
        assign ctl.x_shift   = walk_en && active;
        assign ctl.acc_clr   = eval_start;
        assign ctl.acc_shift = v2_reg && active;
        assign ctl.add_en    = last2_reg && (int'(i2_reg) == p);

        if (p == MAX_VARS - 1) begin : g_end
            assign x_from   = x_c[0];
            assign acc_from = tail_acc;
        end else begin : g_mid
            logic is_tail;

            assign is_tail  = (p + 1) == int'(n_eff);
            assign x_from   = is_tail ? x_c[0] : x_c[p + 1];
            assign acc_from = is_tail ? tail_acc : acc_c[p + 1];
        end

        qog_cell u_cell (
            .aclk     (aclk),
            .ctl      (ctl),
            .wr_value (s_data.value),
            .x_from   (x_from),
            .acc_from (acc_from),
            .add_val  (r_final),
            .x_q      (x_c[p]),
            .l_q      (l_c[p]),
            .acc_q    (acc_c[p])
        );
    end

    logic signed [VAL_W-1:0] l_sel;
    logic signed [ACC_W-1:0] acc_sel;

    assign l_sel   = l_c[sel_ix];
    assign acc_sel = acc_c[sel_ix];

    // ------------------------------------------------------------------
    // Row point value: x[i] held for the whole row, x[i+1] caught on the fly
    // ------------------------------------------------------------------
    logic signed [VAL_W-1:0] xrow_reg, xpend_reg;
    logic next_hit;

    assign next_hit = ({1'b0, j_reg} == ({1'b0, i_reg} + CFG_W'(1)));

    always_ff @(posedge aclk) begin
        if (eval_start) begin
            xrow_reg <= x_c[0];
        end else if (walk_en && (j_reg == n_m1)) begin
            xrow_reg <= next_hit ? x_c[0] : xpend_reg;
        end
        if (walk_en && next_hit) begin
            xpend_reg <= x_c[0];
        end
    end

    // ------------------------------------------------------------------
    // Multiply pipeline
    // ------------------------------------------------------------------
    logic signed [VAL_W-1:0]    xj1_reg, xi1_reg, li1_reg, xi2_reg;
    logic                       first1_reg, last1_reg, first2_reg;
    logic [ELEM_W-1:0]          i1_reg;
    logic signed [PROD_W-1:0]   p1_reg, pl_reg;
    logic signed [TRIPLE_W-1:0] p3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= walk_en;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Stage 1: operands beside the memory read
    always_ff @(posedge aclk) begin
        xj1_reg    <= x_c[0];
        xi1_reg    <= xrow_reg;
        li1_reg    <= l_sel;
        first1_reg <= (j_reg == '0);
        last1_reg  <= (j_reg == n_m1);
        i1_reg     <= i_reg;
    end

    // Stage 2: Q*x[j], Q*x[i], l[i]*x[i]
    always_ff @(posedge aclk) begin
        p1_reg     <= q_reg * xj1_reg;
        p2_reg     <= q_reg * xi1_reg;
        pl_reg     <= li1_reg * xi1_reg;
        xi2_reg    <= xi1_reg;
        first2_reg <= first1_reg;
        last2_reg  <= last1_reg;
        i2_reg     <= i1_reg;
    end

    // Stage 3: x[i]*Q*x[j]
    always_ff @(posedge aclk) begin
        p3_reg <= p1_reg * xi2_reg;
    end

    // ------------------------------------------------------------------
    // Accumulators
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0] r_reg, lin_reg;
    logic signed [RES_W-1:0] quad_reg;

    assign r_final = (first2_reg ? ACC_W'(0) : r_reg) + ACC_W'(p1_reg);

    always_ff @(posedge aclk) begin
        if (eval_start) begin
            lin_reg  <= '0;
            quad_reg <= '0;
        end else begin
            if (v2_reg && first2_reg) begin
                lin_reg <= lin_reg + ACC_W'(pl_reg);
            end
            if (v3_reg) begin
                quad_reg <= quad_reg + RES_W'(p3_reg);
            end
        end
        if (v2_reg) begin
            r_reg <= r_final;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    out_item_t m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (obj_load || grad_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (obj_load) begin
            m_data_reg.kind         <= KIND_OBJ;
            m_data_reg.element      <= '0;
            m_data_reg.result_value <= (quad_reg >>> 1) + (RES_W'(lin_reg) <<< 8);
            m_data_reg.last         <= 1'b0;
        end else if (grad_load) begin
            m_data_reg.kind         <= KIND_GRAD;
            m_data_reg.element      <= e_reg;
            m_data_reg.result_value <= (RES_W'(l_sel) <<< 16) + (RES_W'(acc_sel) <<< 7);
            m_data_reg.last         <= (e_reg == n_m1);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    // Input side only opens once the multiply pipeline has emptied
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !v1_reg && !v2_reg && !v3_reg)
        else $error("input taken while walk pipeline busy");

    // Objective is only formed from a fully drained pipeline
    a_obj_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        obj_load |-> !pipe_busy)
        else $error("objective loaded before accumulation finished");

    // Walk indices stay inside the active square
    a_walk_range: assert property (@(posedge aclk) disable iff (!aresetn)
        walk_en |-> ({1'b0, i_reg} < n_eff) && ({1'b0, j_reg} < n_eff))
        else $error("walk index beyond active count");

    // Only a gradient element can close an evaluation
    a_last_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.last) |-> (m_data.kind == KIND_GRAD))
        else $error("last flag on objective item");
`endif

endmodule

@@ hw/rtl/qog_cell.sv @@
// ----------------------------------------------------------------------------
// qog_cell: one element slot of the variable ring
// Holds a point element, a linear term and a gradient sum; the point and
// gradient sums rotate toward the head cell during the matrix walk.
// ----------------------------------------------------------------------------
module qog_cell import qog_pkg::*; (
    input  logic                    aclk,
    input  cell_ctl_t               ctl,
    input  logic signed [VAL_W-1:0] wr_value,
    input  logic signed [VAL_W-1:0] x_from,
    input  logic signed [ACC_W-1:0] acc_from,
    input  logic signed [ACC_W-1:0] add_val,
    output logic signed [VAL_W-1:0] x_q,
    output logic signed [VAL_W-1:0] l_q,
    output logic signed [ACC_W-1:0] acc_q
);

    logic signed [VAL_W-1:0] x_reg, x_next;
    logic signed [VAL_W-1:0] l_reg, l_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;

    // Point element: load or rotate
    always_comb begin
        x_next = x_reg;
        if (ctl.x_we) begin
            x_next = wr_value;
        end else if (ctl.x_shift) begin
            x_next = x_from;
        end
    end

    assign l_next = ctl.l_we ? wr_value : l_reg;

    // Gradient sum: clear, or take neighbor's sum plus an optional row product
    always_comb begin
        acc_next = acc_reg;
        if (ctl.acc_clr) begin
            acc_next = '0;
        end else if (ctl.acc_shift) begin
            acc_next = acc_from + (ctl.add_en ? add_val : ACC_W'(0));
        end
    end

    always_ff @(posedge aclk) begin
        x_reg   <= x_next;
        l_reg   <= l_next;
        acc_reg <= acc_next;
    end

    assign x_q   = x_reg;
    assign l_q   = l_reg;
    assign acc_q = acc_reg;

endmodule

@@ tb/tb_quadratic_objective_gradient_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quadratic_objective_gradient_top: self-checking bench for the evaluator
// Loads Q, l and x, requests evaluations under several active variable counts
// and checks every objective and gradient item against a local predictor.
// ----------------------------------------------------------------------------
module tb_quadratic_objective_gradient_top;
    import qog_pkg::*;

    localparam int NV        = DEF_MAX_VARS;
    localparam int IDLE_PCT  = 27;
    localparam int WD_LIMIT  = 20000;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [CFG_W-1:0] cfg_data = '0;

    quadratic_objective_gradient_top #(.MAX_VARS(NV)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // predictor state
    logic signed [VAL_W-1:0] mat_q [NV][NV];
    logic signed [VAL_W-1:0] lin_v [NV];
    logic signed [VAL_W-1:0] pt_v [NV];
    logic [CFG_W-1:0]        nvars_reg = 5'd16;

    in_item_t  pending_items[$];
    out_item_t expected_results[$];
    int errors = 0;
    int n_eval = 0;
    int n_res = 0;
    int n_items = 0;
    bit calm = 1'b0;     // no idling stretch
    bit stim_done = 1'b0;
    int quiet = 0;

    function automatic int eff_vars(logic [CFG_W-1:0] v);
        int n;
        n = v;
        if (n == 0) n = 1;
        if (n > NV) n = NV;
        return n;
    endfunction

    // apply one accepted item to the predictor, queue any results
    task automatic predict_item(in_item_t it);
        int n;
        longint quad, lin, acc;
        out_item_t r;
        n = eff_vars(nvars_reg);
        case (op_t'(it.operation))
            OP_WR_MATRIX: mat_q[it.row][it.col] = it.value;
            OP_WR_LINEAR: lin_v[it.row] = it.value;
            OP_WR_POINT:  pt_v[it.row] = it.value;
            default: begin
                quad = 0;
                lin = 0;
                for (int i = 0; i < n; i++) begin
                    for (int j = 0; j < n; j++)
                        quad += longint'(pt_v[i]) * longint'(mat_q[i][j]) * longint'(pt_v[j]);
                    lin += longint'(lin_v[i]) * longint'(pt_v[i]);
                end
                r.kind = KIND_OBJ;
                r.element = '0;
                r.result_value = (quad >>> 1) + lin * 256;
                r.last = 1'b0;
                expected_results.push_back(r);
                for (int i = 0; i < n; i++) begin
                    acc = 0;
                    for (int j = 0; j < n; j++)
                        acc += (longint'(mat_q[i][j]) + longint'(mat_q[j][i]))
                               * longint'(pt_v[j]);
                    r.kind = KIND_GRAD;
                    r.element = i[ELEM_W-1:0];
                    r.result_value = longint'(lin_v[i]) * 65536 + acc * 128;
                    r.last = (i == n - 1);
                    expected_results.push_back(r);
                end
            end
        endcase
    endtask

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    function automatic logic [VAL_W-1:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'hFFFF;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    function automatic in_item_t mk(op_t op, int r, int c, logic [VAL_W-1:0] v);
        in_item_t it;
        it.operation = op;
        it.row = ELEM_W'(r);
        it.col = ELEM_W'(c);
        it.value = v;
        return it;
    endfunction

    // driver: idles at random, holds an item until it is taken
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_item(s_data);
                n_items++;
                if (op_t'(s_data.operation) == OP_EVAL) n_eval++;
            end
            if (!s_valid || s_ready) begin
                if (pending_items.size() > 0 &&
                    (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    s_data <= pending_items.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: random back pressure, compare with oldest expectation
    always @(posedge aclk) begin
        out_item_t e;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                n_res++;
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing expected");
                end else begin
                    e = expected_results.pop_front();
                    if (m_data.kind !== e.kind)
                        report_mismatch($sformatf("kind %0b want %0b", m_data.kind, e.kind));
                    if (m_data.element !== e.element)
                        report_mismatch($sformatf("element %0d want %0d",
                                        m_data.element, e.element));
                    if (m_data.result_value !== e.result_value)
                        report_mismatch($sformatf("value %0d want %0d",
                                        m_data.result_value, e.result_value));
                    if (m_data.last !== e.last)
                        report_mismatch($sformatf("last %0b want %0b", m_data.last, e.last));
                end
            end
            m_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // watchdog: cycles with no item moving on any channel
    always @(posedge aclk) begin
        if (aresetn && !stim_done) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (quiet >= WD_LIMIT) begin
                $display("watchdog expired, %0d results outstanding",
                         expected_results.size());
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic wait_drain();
        while (pending_items.size() > 0 || s_valid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_nvars(logic [CFG_W-1:0] v);
        cfg_data <= v;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        nvars_reg = v;
        cfg_valid <= 1'b0;
    endtask

    // full load of every entry, so no unwritten entry is ever read
    task automatic load_all(int mode);
        for (int i = 0; i < NV; i++) begin
            for (int j = 0; j < NV; j++)
                pending_items.push_back(mk(OP_WR_MATRIX, i, j,
                    mode == 1 ? 16'h7FFF : mode == 2 ? 16'h8000 : rand_value()));
            pending_items.push_back(mk(OP_WR_LINEAR, i, $urandom,
                mode == 1 ? 16'h7FFF : mode == 2 ? 16'h8000 : rand_value()));
            pending_items.push_back(mk(OP_WR_POINT, i, $urandom,
                mode == 1 ? 16'h8000 : mode == 2 ? 16'h8000 : rand_value()));
        end
    endtask

    task automatic random_phase(int count);
        op_t op;
        for (int k = 0; k < count; k++) begin
            op = op_t'($urandom_range(0, 3));
            if ($urandom_range(0, 3) == 0) op = OP_EVAL;
            pending_items.push_back(mk(op, $urandom, $urandom, rand_value()));
        end
    endtask

    initial begin
        int settings[6];
        settings = '{16, 1, 0, 31, 5, 17};
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes with full matrix loaded, then evaluate
        calm = 1'b1;
        load_all(1);
        pending_items.push_back(mk(OP_EVAL, 15, 15, 16'hFFFF));
        pending_items.push_back(mk(OP_WR_POINT, 0, 0, 16'h7FFF));
        pending_items.push_back(mk(OP_EVAL, 0, 0, 16'h0000));
        wait_drain();
        calm = 1'b0;

        // random phases under several active counts, extremes included
        foreach (settings[s]) begin
            write_nvars(settings[s][CFG_W-1:0]);
            random_phase(23);
            wait_drain();
        end
        stim_done = 1'b1;

        $display("%0d items sent, %0d evaluations, %0d results checked",
                 n_items, n_eval, n_res);
        $display("active counts 16, 1, 0, 31, 5 and 17 exercised");
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
